FILE: rtl/core/rigid_body_velocity_integrator_core_assert.svh
// assertion helpers shared by the checker, clocked on clk, quiet while rst is high
`ifndef RIGID_BODY_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH
`define RIGID_BODY_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH

// same-cycle implication
`define RBVI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbvi assertion failed");

// next-cycle implication
`define RBVI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbvi assertion failed");

`endif

FILE: rtl/core/rbvi_pkg.sv
`timescale 1ns / 1ps

package rbvi_pkg;

  localparam int VAL_W      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_BITS  = 16;
  localparam int UNIT_BITS  = 30;
  localparam int ACC_W      = VAL_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(ACC_W + 1);
  localparam int MUL_W      = VAL_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BODY_MASS      = 3'd0,
    REG_DAMPING_RATE   = 3'd1,
    REG_GRAVITY_ACCEL  = 3'd2,
    REG_STOP_THRESHOLD = 3'd3,
    REG_GRAVITY_ENABLE = 3'd4,
    REG_STATIC_MODE    = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FORCE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_POS_M,
    ST_T_POS_W,
    ST_T_DMP_M,
    ST_T_DMP_W,
    ST_T_GRV_M,
    ST_T_GRV_W,
    ST_T_SQ_M,
    ST_T_SQ_W,
    ST_T_STOP,
    ST_F_SQ_M,
    ST_F_SQ_W,
    ST_F_CHK,
    ST_F_ROOT,
    ST_F_ACC,
    ST_F_UNIT,
    ST_F_LO,
    ST_F_HI,
    ST_F_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [VAL_W-1:0]     divisor;
    logic [VAL_W-1:0]     rem_init;
    logic [ACC_W-1:0]     quo_init;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [VAL_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] x);
    sat_t r;
    r.ovf = 1'b0;
    r.val = x[VAL_W-1:0];
    if (!(x[PROD_W-1:VAL_W-1] == '0 || x[PROD_W-1:VAL_W-1] == '1)) begin
      r.ovf = 1'b1;
      r.val = x[PROD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

FILE: rtl/core/rbvi_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle
module rbvi_div import rbvi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [ACC_W-1:0] quo
);

  logic [VAL_W-1:0]     rem_q, rem_next;
  logic [VAL_W-1:0]     dvs_q;
  logic [ACC_W-1:0]     quo_q, quo_next;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [VAL_W:0]       shifted, diff;

  always_comb begin
    shifted = {rem_q, quo_q[ACC_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (!diff[VAL_W]) begin
      rem_next = diff[VAL_W-1:0];
      quo_next = {quo_q[ACC_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[VAL_W-1:0];
      quo_next = {quo_q[ACC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_q <= req.rem_init;
      quo_q <= req.quo_init;
      dvs_q <= req.divisor;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
  end

  assign done = done_q;
  assign quo  = quo_q;

endmodule

FILE: rtl/core/rbvi_sqrt.sv
`timescale 1ns / 1ps

// bit-pair integer square root, one result bit a cycle
module rbvi_sqrt import rbvi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2*VAL_W-1:0]   radicand,
  output logic                 done,
  output logic [VAL_W-1:0]     root
);

  logic [2*VAL_W-1:0] s_q, res_q, bit_q, trial;
  logic               busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_q   <= radicand;
      res_q <= '0;
      bit_q <= {2'b01, {(2*VAL_W-2){1'b0}}};
    end else if (busy_q) begin
      if (s_q >= trial) begin
        s_q   <= s_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done = done_q;
  assign root = res_q[VAL_W-1:0];

endmodule

FILE: rtl/core/rigid_body_velocity_integrator_core.sv
`timescale 1ns / 1ps

// explicit euler integrator for one rigid body, signed q16.16 state
// configuration: cfg_we/cfg_addr/cfg_data write one register per clock;
//   the user must write only while the core is idle, as the core itself has no check for this
// input stream s_*: s_tuser is the item kind (tick or force), s_tdata the
//   time step, force power and direction; one transfer per item
// output stream m_*: one transfer per item carrying position, velocity and
//   the saturation flag of the state after the item
// a tick makes three multiply/write passes over the axes, gravity (if
//   enabled) and the stop test; a static tick goes straight to the result
// a force item takes the squared length, a square root, a division by mass
//   and three unit divisions (only the squared length for a zero direction);
//   the divisions share one divider and the products one 33x33 multiplier
// one item is worked on at a time; s_tready is high only while idle, and a
//   finished result sits in the output register so the next item can be
//   taken while m_tvalid waits for m_tready
// when the receiver stalls, the next result waits in the done state
// reset clears position, velocity, the output valid and restores the
//   register defaults
module rigid_body_velocity_integrator_core import rbvi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // time_step[15:0], force_power[47:16], dir_x[79:48], dir_y[111:80], dir_z[143:112]
  input  logic [143:0]          s_tdata,
  // op[0]
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0 up
  output logic [191:0]          m_tdata,
  // saturated[0]
  output logic [0:0]            m_tuser
);

  // configuration registers
  logic [31:0] body_mass_q, gravity_accel_q, stop_threshold_q;
  logic [16:0] damping_rate_q;
  logic        gravity_enable_q, static_mode_q;

  // body state
  logic signed [VAL_W-1:0] pos_q [3];
  logic signed [VAL_W-1:0] vel_q [3];

  // latched item
  op_t                     op_q;
  logic [15:0]             dt_q;
  logic signed [VAL_W-1:0] pow_q;
  logic signed [VAL_W-1:0] dir_q [3];

  // working registers
  state_t                   state_q, state_next;
  logic [1:0]               idx_q;
  logic                     flag_q;
  logic [2*VAL_W-1:0]       sq_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [PROD_W-1:0] prod_q, tmp_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  // output register
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_pos_q [3];
  logic signed [VAL_W-1:0] out_vel_q [3];
  logic                    out_sat_q;

  // shared units
  div_req_t         div_req;
  logic             div_done;
  logic [ACC_W-1:0] div_quo;
  logic             sqrt_start, sqrt_done;
  logic [VAL_W-1:0] root;

  logic                     in_xfer, out_load, last_axis, stop_hit, dir_neg;
  logic [1:0]               dsel;
  logic [VAL_W-1:0]         dmag;
  logic [UNIT_BITS:0]       unit_val;
  logic signed [PROD_W-1:0] wb_sum, dmag_sum;
  sat_t                     wb_sat;

  assign in_xfer   = s_tvalid && s_tready;
  assign last_axis = (idx_q == 2'd2);
  assign stop_hit  = (sq_q >> FRAC_BITS) <= (2*VAL_W)'(stop_threshold_q);
  assign unit_val  = div_quo[UNIT_BITS:0];
  assign dir_neg   = pow_q[VAL_W-1] != dir_q[idx_q][VAL_W-1];
  assign dmag_sum  = prod_q + tmp_q;

  rbvi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  rbvi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_q),
    .done     (sqrt_done),
    .root     (root)
  );

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op_t'(s_tuser[0]) == OP_FORCE) state_next = ST_F_SQ_M;
          else if (static_mode_q)            state_next = ST_DONE;
          else                               state_next = ST_T_POS_M;
        end
      end
      ST_T_POS_M: state_next = ST_T_POS_W;
      ST_T_POS_W: state_next = last_axis ? ST_T_DMP_M : ST_T_POS_M;
      ST_T_DMP_M: state_next = ST_T_DMP_W;
      ST_T_DMP_W: begin
        if (!last_axis)            state_next = ST_T_DMP_M;
        else if (gravity_enable_q) state_next = ST_T_GRV_M;
        else                       state_next = ST_T_SQ_M;
      end
      ST_T_GRV_M: state_next = ST_T_GRV_W;
      ST_T_GRV_W: state_next = ST_T_SQ_M;
      ST_T_SQ_M:  state_next = ST_T_SQ_W;
      ST_T_SQ_W:  state_next = last_axis ? ST_T_STOP : ST_T_SQ_M;
      ST_T_STOP:  state_next = ST_DONE;
      ST_F_SQ_M:  state_next = ST_F_SQ_W;
      ST_F_SQ_W:  state_next = last_axis ? ST_F_CHK : ST_F_SQ_M;
      ST_F_CHK:   state_next = (sq_q == '0) ? ST_DONE : ST_F_ROOT;
      ST_F_ROOT:  if (sqrt_done) state_next = ST_F_ACC;
      ST_F_ACC:   if (div_done) state_next = ST_F_UNIT;
      ST_F_UNIT:  if (div_done) state_next = ST_F_LO;
      ST_F_LO:    state_next = ST_F_HI;
      ST_F_HI:    state_next = ST_F_ADD;
      ST_F_ADD:   state_next = last_axis ? ST_DONE : ST_F_UNIT;
      ST_DONE:    if (!out_valid_q || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // unit control, multiplier operands, write-back selection
  always_comb begin
    s_tready   = 1'b0;
    out_load   = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    wb_sum     = '0;
    dsel       = idx_q;
    div_req    = '0;
    case (state_q)
      ST_IDLE: s_tready = 1'b1;
      ST_T_POS_M: begin
        mul_a = MUL_W'(vel_q[idx_q]);
        mul_b = MUL_W'(dt_q);
      end
      ST_T_POS_W: wb_sum = PROD_W'(pos_q[idx_q]) + (prod_q >>> STEP_BITS);
      ST_T_DMP_M: begin
        mul_a = MUL_W'(vel_q[idx_q]);
        mul_b = MUL_W'(damping_rate_q);
      end
      ST_T_DMP_W: wb_sum = prod_q >>> STEP_BITS;
      ST_T_GRV_M: begin
        mul_a = MUL_W'(gravity_accel_q);
        mul_b = MUL_W'(dt_q);
      end
      ST_T_GRV_W: wb_sum = PROD_W'(vel_q[1]) - (prod_q >>> STEP_BITS);
      ST_T_SQ_M: begin
        mul_a = MUL_W'(vel_q[idx_q]);
        mul_b = MUL_W'(vel_q[idx_q]);
      end
      ST_F_SQ_M: begin
        mul_a = MUL_W'(dir_q[idx_q]);
        mul_b = MUL_W'(dir_q[idx_q]);
      end
      ST_F_CHK: sqrt_start = (sq_q != '0);
      ST_F_ROOT: begin
        // acceleration magnitude: |power| scaled up, over mass (zero read as one lsb)
        div_req.start    = sqrt_done;
        div_req.divisor  = (body_mass_q == '0) ? VAL_W'(1) : body_mass_q;
        div_req.rem_init = '0;
        div_req.quo_init = {mag32(pow_q), {FRAC_BITS{1'b0}}};
        div_req.steps    = DIV_CNT_W'(ACC_W);
      end
      ST_F_ACC: begin
        dsel          = 2'd0;
        div_req.start = div_done;
      end
      ST_F_LO: begin
        mul_a = MUL_W'(acc_q[UNIT_BITS-1:0]);
        mul_b = MUL_W'(unit_val);
      end
      ST_F_HI: begin
        mul_a = MUL_W'(acc_q[ACC_W-1:UNIT_BITS]);
        mul_b = MUL_W'(unit_val);
      end
      ST_F_ADD: begin
        wb_sum        = dir_neg ? (PROD_W'(vel_q[idx_q]) - dmag_sum)
                                : (PROD_W'(vel_q[idx_q]) + dmag_sum);
        dsel          = idx_q + 2'd1;
        div_req.start = !last_axis;
      end
      ST_DONE: out_load = !out_valid_q || m_tready;
      default: ;
    endcase
    // unit vector component: |d| << 30 over the length; the quotient fits
    // in 31 bits since |d| never exceeds the length, so the top bits start
    // straight in the remainder
    if (state_q == ST_F_ACC || state_q == ST_F_ADD) begin
      dmag             = mag32(dir_q[dsel]);
      div_req.divisor  = root;
      div_req.rem_init = {1'b0, dmag[VAL_W-1:1]};
      div_req.quo_init = {dmag[0], {(ACC_W-1){1'b0}}};
      div_req.steps    = DIV_CNT_W'(UNIT_BITS + 1);
    end else begin
      dmag = '0;
    end
  end

  assign wb_sat = sat32(wb_sum);

  // control state, configuration, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q          <= ST_IDLE;
      idx_q            <= '0;
      out_valid_q      <= 1'b0;
      body_mass_q      <= 32'd65536;
      damping_rate_q   <= 17'd65536;
      gravity_accel_q  <= 32'd642253;
      stop_threshold_q <= '0;
      gravity_enable_q <= 1'b0;
      static_mode_q    <= 1'b0;
    end else begin
      state_q <= state_next;
      case (state_q)
        ST_IDLE, ST_F_ACC: idx_q <= '0;
        ST_T_POS_W, ST_T_DMP_W, ST_T_SQ_W, ST_F_SQ_W, ST_F_ADD:
          idx_q <= last_axis ? 2'd0 : idx_q + 2'd1;
        ST_T_GRV_W: idx_q <= '0;
        default: ;
      endcase
      if (out_load)      out_valid_q <= 1'b1;
      else if (m_tready) out_valid_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_BODY_MASS:      body_mass_q      <= cfg_data;
          REG_DAMPING_RATE:   damping_rate_q   <= cfg_data[16:0];
          REG_GRAVITY_ACCEL:  gravity_accel_q  <= cfg_data;
          REG_STOP_THRESHOLD: stop_threshold_q <= cfg_data;
          REG_GRAVITY_ENABLE: gravity_enable_q <= cfg_data[0];
          REG_STATIC_MODE:    static_mode_q    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // body state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_T_POS_W:           pos_q[idx_q] <= wb_sat.val;
        ST_T_DMP_W, ST_F_ADD: vel_q[idx_q] <= wb_sat.val;
        ST_T_GRV_W:           vel_q[1]     <= wb_sat.val;
        ST_T_STOP: begin
          if (stop_hit) begin
            for (int i = 0; i < 3; i++) vel_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_q     <= op_t'(s_tuser[0]);
          dt_q     <= s_tdata[15:0];
          pow_q    <= s_tdata[47:16];
          dir_q[0] <= s_tdata[79:48];
          dir_q[1] <= s_tdata[111:80];
          dir_q[2] <= s_tdata[143:112];
          sq_q     <= '0;
          flag_q   <= 1'b0;
        end
      end
      ST_T_POS_W, ST_T_DMP_W, ST_T_GRV_W, ST_F_ADD: flag_q <= flag_q | wb_sat.ovf;
      ST_T_SQ_W, ST_F_SQ_W: sq_q <= sq_q + prod_q[2*VAL_W-1:0];
      ST_F_ACC: if (div_done) acc_q <= div_quo;
      ST_F_HI:  tmp_q <= prod_q >>> UNIT_BITS;
      default: ;
    endcase
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_pos_q[i] <= pos_q[i];
        out_vel_q[i] <= vel_q[i];
      end
      // a force item with a zero direction reports no clamp
      out_sat_q <= (op_q == OP_FORCE && sq_q == '0) ? 1'b0 : flag_q;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {out_vel_q[2], out_vel_q[1], out_vel_q[0],
                     out_pos_q[2], out_pos_q[1], out_pos_q[0]};
  assign m_tuser  = out_sat_q;

endmodule

FILE: rtl/core/rbvi_checker.sv
`timescale 1ns / 1ps

`include "rigid_body_velocity_integrator_core_assert.svh"

module rbvi_checker import rbvi_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // a stalled result holds
  `RBVI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // an accepted item keeps the core busy in the next cycle
  `RBVI_ASSERT_NXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready)

  // a new result only appears at the end of a busy stretch
  `RBVI_ASSERT_IMP(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

  // no result can appear in the cycle straight after an accepted item
  `RBVI_ASSERT_NXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind rigid_body_velocity_integrator_core rbvi_checker u_rbvi_checker (.*);
